/* sv/frp_pkg.sv */
// Shared types and constants for the FASTA/FASTQ record parser.
`default_nettype none
package frp_pkg;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [1:0] REG_FORMAT_FASTQ  = 2'd0;
	localparam logic [1:0] REG_DROP_NAME     = 2'd1;
	localparam logic [1:0] REG_DROP_SEQUENCE = 2'd2;
	localparam logic [1:0] REG_DROP_QUALITY  = 2'd3;

	localparam logic [2:0] TAG_NAME    = 3'd0;
	localparam logic [2:0] TAG_COMMENT = 3'd1;
	localparam logic [2:0] TAG_SEQ     = 3'd2;
	localparam logic [2:0] TAG_QUAL    = 3'd3;
	localparam logic [2:0] TAG_END     = 3'd4;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_HEADER   = 3'd1;
	localparam logic [2:0] PH_BODY     = 3'd2;
	localparam logic [2:0] PH_SEEK     = 3'd3;
	localparam logic [2:0] PH_PLUS     = 3'd4;
	localparam logic [2:0] PH_QUAL     = 3'd5;

	localparam logic [1:0] HP_NONE     = 2'd0;
	localparam logic [1:0] HP_NAME     = 2'd1;
	localparam logic [1:0] HP_COMMENT  = 2'd2;

	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_EOI  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0] field_tag;
		logic [7:0] data_byte;
		logic       record_ok;
	} out_item_t;

	typedef struct packed {
		logic format_fastq;
		logic drop_name;
		logic drop_sequence;
		logic drop_quality;
	} cfg_t;

	typedef struct packed {
		logic [2:0] record_phase;
		logic       at_line_start;
		logic [1:0] header_part;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		record_phase:  PH_IDLE,
		at_line_start: 1'b1,
		header_part:   HP_NONE
	};

endpackage
`default_nettype wire

/* sv/fasta_fastq_record_parser_unit.sv */
// Top level of the FASTA/FASTQ record parser: input register, parse core, result register.
// The input channel (item_valid, item_ready, item) carries one stream byte or an
// end-of-input mark per transfer. The result channel (result_valid, result_ready,
// result) carries tagged name, comment, sequence and quality bytes and record ends.
// Each input transfer gives zero or one result transfer.
// An accepted item waits in the input register until the result register can take its
// result; then it updates the parse state and its result goes to the result register.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls with a result pending, the item in the input register
// waits, and item_ready drops until the result register can be reloaded.
// Reset clears both valid flags, the parse state (no record open, at line start)
// and all configuration registers (FASTA mode, nothing dropped).
// The APB port takes writes in a setup and an access phase; a write to the format
// register also clears the parse state. Registers are to be written only while idle;
// the block itself does not enforce it.
`default_nettype none
module fasta_fastq_record_parser_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire frp_pkg::in_item_t             item,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output frp_pkg::out_item_t                 result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [frp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [frp_pkg::PDATA_W-1:0]   pwdata,
	output logic      [frp_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);

	frp_pkg::cfg_t      cfg;
	logic               parse_clear;
	logic               valid_s1;
	frp_pkg::in_item_t  item_s1;
	logic               proc;
	logic               step_valid;
	frp_pkg::out_item_t step_res;
	logic               result_valid_q;
	frp_pkg::out_item_t result_q;

	frp_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cfg         (cfg),
		.parse_clear (parse_clear)
	);

	frp_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (proc),
		.parse_clear (parse_clear),
		.cfg         (cfg),
		.item        (item_s1),
		.res_valid   (step_valid),
		.res         (step_res)
	);

	assign proc       = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (proc) begin
			result_valid_q <= step_valid;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && step_valid) begin
			result_q <= step_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

/* sv/frp_cfg_regs.sv */
// APB configuration registers of the record parser.
`default_nettype none
module frp_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [frp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [frp_pkg::PDATA_W-1:0]   pwdata,
	output logic      [frp_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output frp_pkg::cfg_t                      cfg,
	output logic                               parse_clear
);

	frp_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;
	logic          rd_bit;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;
	assign parse_clear = wr_en && (reg_idx == frp_pkg::REG_FORMAT_FASTQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				frp_pkg::REG_FORMAT_FASTQ:  cfg_q.format_fastq  <= pwdata[0];
				frp_pkg::REG_DROP_NAME:     cfg_q.drop_name     <= pwdata[0];
				frp_pkg::REG_DROP_SEQUENCE: cfg_q.drop_sequence <= pwdata[0];
				frp_pkg::REG_DROP_QUALITY:  cfg_q.drop_quality  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			frp_pkg::REG_FORMAT_FASTQ:  rd_bit = cfg_q.format_fastq;
			frp_pkg::REG_DROP_NAME:     rd_bit = cfg_q.drop_name;
			frp_pkg::REG_DROP_SEQUENCE: rd_bit = cfg_q.drop_sequence;
			frp_pkg::REG_DROP_QUALITY:  rd_bit = cfg_q.drop_quality;
			default:                    rd_bit = 1'b0;
		endcase
		prdata = {{(frp_pkg::PDATA_W-1){1'b0}}, rd_bit};
	end

endmodule
`default_nettype wire

/* sv/frp_parse_core.sv */
// Parse state registers and the per-item state update with result selection.
`default_nettype none
module frp_parse_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire logic              parse_clear,
	input  wire frp_pkg::cfg_t     cfg,
	input  wire frp_pkg::in_item_t item,
	output logic                   res_valid,
	output frp_pkg::out_item_t     res
);

	frp_pkg::parse_state_t st_q;
	frp_pkg::parse_state_t st_d;
	logic [7:0]            b;
	logic                  ls;
	logic [2:0]            ph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= frp_pkg::STATE_RESET;
		end else if (parse_clear) begin
			st_q <= frp_pkg::STATE_RESET;
		end else if (step_en) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		res_valid = 1'b0;
		res       = '0;
		b         = item.byte_value;
		ls        = st_q.at_line_start;
		ph        = st_q.record_phase;
		if (item.kind == frp_pkg::KIND_EOI) begin
			st_d = frp_pkg::STATE_RESET;
			res.field_tag = frp_pkg::TAG_END;
			if (cfg.format_fastq) begin
				if (ph >= frp_pkg::PH_HEADER && ph <= frp_pkg::PH_PLUS) begin
					res_valid = 1'b1;
				end else if (ph == frp_pkg::PH_QUAL) begin
					res_valid     = 1'b1;
					res.record_ok = !ls;
				end
			end else if (ph != frp_pkg::PH_IDLE) begin
				res_valid     = 1'b1;
				res.record_ok = (ph == frp_pkg::PH_BODY);
			end
		end else begin
			st_d.at_line_start = (b == frp_pkg::CH_NL);
			res.data_byte      = b;
			if (cfg.format_fastq) begin
				case (ph)
					frp_pkg::PH_HEADER: begin
						if (b == frp_pkg::CH_NL) begin
							st_d.record_phase = frp_pkg::PH_BODY;
							st_d.header_part  = frp_pkg::HP_NONE;
						end else if (st_q.header_part == frp_pkg::HP_NAME) begin
							if (b == frp_pkg::CH_SPACE || b == frp_pkg::CH_TAB) begin
								st_d.header_part = frp_pkg::HP_COMMENT;
							end else begin
								res_valid     = !cfg.drop_name;
								res.field_tag = frp_pkg::TAG_NAME;
							end
						end else begin
							res_valid     = !cfg.drop_name;
							res.field_tag = frp_pkg::TAG_COMMENT;
						end
					end
					frp_pkg::PH_BODY: begin
						if (b == frp_pkg::CH_NL) begin
							st_d.record_phase = frp_pkg::PH_SEEK;
						end else begin
							res_valid     = !cfg.drop_sequence;
							res.field_tag = frp_pkg::TAG_SEQ;
						end
					end
					frp_pkg::PH_SEEK: begin
						if (ls && b == frp_pkg::CH_PLUS) begin
							st_d.record_phase = frp_pkg::PH_PLUS;
						end
					end
					frp_pkg::PH_PLUS: begin
						if (b == frp_pkg::CH_NL) begin
							st_d.record_phase = frp_pkg::PH_QUAL;
						end
					end
					frp_pkg::PH_QUAL: begin
						if (b == frp_pkg::CH_NL) begin
							st_d.record_phase = frp_pkg::PH_IDLE;
							res_valid         = 1'b1;
							res.field_tag     = frp_pkg::TAG_END;
							res.data_byte     = '0;
							res.record_ok     = 1'b1;
						end else begin
							res_valid     = !cfg.drop_quality;
							res.field_tag = frp_pkg::TAG_QUAL;
						end
					end
					default: begin
						st_d.record_phase = frp_pkg::PH_IDLE;
						st_d.header_part  = frp_pkg::HP_NONE;
						if (ls && b == frp_pkg::CH_AT) begin
							st_d.record_phase = frp_pkg::PH_HEADER;
							st_d.header_part  = frp_pkg::HP_NAME;
						end
					end
				endcase
			end else begin
				if (ph > frp_pkg::PH_BODY) begin
					ph = frp_pkg::PH_IDLE;
				end
				st_d.record_phase = ph;
				if (ls) begin
					if (b == frp_pkg::CH_GT) begin
						res_valid         = (ph != frp_pkg::PH_IDLE);
						res.field_tag     = frp_pkg::TAG_END;
						res.data_byte     = '0;
						res.record_ok     = (ph == frp_pkg::PH_BODY);
						st_d.record_phase = frp_pkg::PH_HEADER;
						st_d.header_part  = frp_pkg::HP_NAME;
					end else begin
						st_d.header_part  = frp_pkg::HP_NONE;
						st_d.record_phase = frp_pkg::PH_BODY;
						res_valid         = (b != frp_pkg::CH_NL) && !cfg.drop_sequence;
						res.field_tag     = frp_pkg::TAG_SEQ;
					end
				end else if (b == frp_pkg::CH_NL) begin
					st_d.header_part = frp_pkg::HP_NONE;
				end else if (st_q.header_part == frp_pkg::HP_NAME) begin
					if (b == frp_pkg::CH_SPACE || b == frp_pkg::CH_TAB ||
						b == frp_pkg::CH_CR) begin
						st_d.header_part = frp_pkg::HP_COMMENT;
					end else begin
						res_valid     = !cfg.drop_name;
						res.field_tag = frp_pkg::TAG_NAME;
					end
				end else if (st_q.header_part == frp_pkg::HP_COMMENT) begin
					res_valid     = !cfg.drop_name;
					res.field_tag = frp_pkg::TAG_COMMENT;
				end else begin
					st_d.record_phase = frp_pkg::PH_BODY;
					res_valid         = !cfg.drop_sequence;
					res.field_tag     = frp_pkg::TAG_SEQ;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* sv/frp_checker.sv */
// Port-level checker for the record parser and its bind to the top level.
`default_nettype none
module frp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire frp_pkg::out_item_t result
);

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
	else $error("Result changed or dropped while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.field_tag <= frp_pkg::TAG_END)
	else $error("Result carries an undefined field tag.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.field_tag != frp_pkg::TAG_END |-> !result.record_ok)
	else $error("Data byte transfer has record_ok set.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.field_tag == frp_pkg::TAG_END |-> result.data_byte == 8'h00)
	else $error("Record end carries a nonzero data byte.");

endmodule

bind fasta_fastq_record_parser_unit frp_checker u_frp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the FASTA/FASTQ record parser: random streams, APB setup, scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 90;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	frp_pkg::in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	frp_pkg::out_item_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [frp_pkg::PADDR_W-1:0] paddr = '0;
	logic [frp_pkg::PDATA_W-1:0] pwdata = '0;
	logic [frp_pkg::PDATA_W-1:0] prdata;
	logic pready;

	frp_pkg::in_item_t stream_q[$];
	frp_pkg::out_item_t tagged_q[$];
	logic [7:0] rec_buf[$];
	frp_pkg::cfg_t cfg = '0;
	frp_pkg::parse_state_t st = frp_pkg::STATE_RESET;
	int fed = 0;
	int mismatches = 0;
	bit steady = 1'b0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	fasta_fastq_record_parser_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	task automatic flag(input string what);
		mismatches++;
		if (mismatches <= 100) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
	endtask

	function automatic bit idle_now();
		return !steady && ($urandom_range(0, 99) < 9);
	endfunction

	// Advances the parse state by one item and returns 1 when the item yields a result.
	function automatic bit parse_step(input frp_pkg::in_item_t it, output frp_pkg::out_item_t res);
		logic [7:0] b;
		logic ls;
		logic [2:0] tag;
		logic ok;
		bit hit;
		bit drop;
		b = it.byte_value;
		tag = frp_pkg::TAG_END;
		ok = 1'b0;
		hit = 1'b0;
		drop = 1'b0;
		if (it.kind == frp_pkg::KIND_EOI) begin
			if (cfg.format_fastq) begin
				hit = st.record_phase >= frp_pkg::PH_HEADER &&
					st.record_phase <= frp_pkg::PH_QUAL;
				ok = st.record_phase == frp_pkg::PH_QUAL && !st.at_line_start;
			end else begin
				hit = st.record_phase != frp_pkg::PH_IDLE;
				ok = st.record_phase == frp_pkg::PH_BODY;
			end
			st = frp_pkg::STATE_RESET;
		end else begin
			ls = st.at_line_start;
			st.at_line_start = (b == frp_pkg::CH_NL);
			if (cfg.format_fastq) begin
				case (st.record_phase)
				frp_pkg::PH_HEADER: begin
					if (b == frp_pkg::CH_NL) begin
						st.record_phase = frp_pkg::PH_BODY;
						st.header_part = frp_pkg::HP_NONE;
					end else if (st.header_part == frp_pkg::HP_NAME &&
						(b == frp_pkg::CH_SPACE || b == frp_pkg::CH_TAB)) begin
						st.header_part = frp_pkg::HP_COMMENT;
					end else begin
						hit = 1'b1;
						tag = (st.header_part == frp_pkg::HP_NAME) ?
							frp_pkg::TAG_NAME : frp_pkg::TAG_COMMENT;
						drop = cfg.drop_name;
					end
				end
				frp_pkg::PH_BODY: begin
					if (b == frp_pkg::CH_NL) begin
						st.record_phase = frp_pkg::PH_SEEK;
					end else begin
						hit = 1'b1;
						tag = frp_pkg::TAG_SEQ;
						drop = cfg.drop_sequence;
					end
				end
				frp_pkg::PH_SEEK: begin
					if (ls && b == frp_pkg::CH_PLUS) st.record_phase = frp_pkg::PH_PLUS;
				end
				frp_pkg::PH_PLUS: begin
					if (b == frp_pkg::CH_NL) st.record_phase = frp_pkg::PH_QUAL;
				end
				frp_pkg::PH_QUAL: begin
					hit = 1'b1;
					if (b == frp_pkg::CH_NL) begin
						st.record_phase = frp_pkg::PH_IDLE;
						ok = 1'b1;
					end else begin
						tag = frp_pkg::TAG_QUAL;
						drop = cfg.drop_quality;
					end
				end
				default: begin
					st.record_phase = frp_pkg::PH_IDLE;
					st.header_part = frp_pkg::HP_NONE;
					if (ls && b == frp_pkg::CH_AT) begin
						st.record_phase = frp_pkg::PH_HEADER;
						st.header_part = frp_pkg::HP_NAME;
					end
				end
				endcase
			end else begin
				if (st.record_phase > frp_pkg::PH_BODY) st.record_phase = frp_pkg::PH_IDLE;
				if (ls) begin
					if (b == frp_pkg::CH_GT) begin
						hit = st.record_phase != frp_pkg::PH_IDLE;
						ok = st.record_phase == frp_pkg::PH_BODY;
						st.record_phase = frp_pkg::PH_HEADER;
						st.header_part = frp_pkg::HP_NAME;
					end else begin
						st.header_part = frp_pkg::HP_NONE;
						st.record_phase = frp_pkg::PH_BODY;
						if (b != frp_pkg::CH_NL) begin
							hit = 1'b1;
							tag = frp_pkg::TAG_SEQ;
							drop = cfg.drop_sequence;
						end
					end
				end else if (b == frp_pkg::CH_NL) begin
					st.header_part = frp_pkg::HP_NONE;
				end else if (st.header_part == frp_pkg::HP_NAME) begin
					if (b == frp_pkg::CH_SPACE || b == frp_pkg::CH_TAB ||
						b == frp_pkg::CH_CR) begin
						st.header_part = frp_pkg::HP_COMMENT;
					end else begin
						hit = 1'b1;
						tag = frp_pkg::TAG_NAME;
						drop = cfg.drop_name;
					end
				end else if (st.header_part == frp_pkg::HP_COMMENT) begin
					hit = 1'b1;
					tag = frp_pkg::TAG_COMMENT;
					drop = cfg.drop_name;
				end else begin
					st.record_phase = frp_pkg::PH_BODY;
					hit = 1'b1;
					tag = frp_pkg::TAG_SEQ;
					drop = cfg.drop_sequence;
				end
			end
		end
		res.field_tag = tag;
		res.data_byte = (tag == frp_pkg::TAG_END) ? 8'h00 : b;
		res.record_ok = (tag == frp_pkg::TAG_END) ? ok : 1'b0;
		return hit && !drop;
	endfunction

	// Sender: offers queued items and predicts each one at its transfer.
	always @(posedge clk) begin
		frp_pkg::out_item_t res;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				if (parse_step(item, res)) tagged_q.push_back(res);
			end
			if (!item_valid || item_ready) begin
				if (stream_q.size() != 0 && !idle_now()) begin
					item_valid <= 1'b1;
					item <= stream_q.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer against the oldest prediction.
	always @(posedge clk) begin
		frp_pkg::out_item_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (tagged_q.size() == 0) begin
					flag($sformatf("unexpected result tag %0d byte %02h ok %0d",
						result.field_tag, result.data_byte, result.record_ok));
				end else begin
					want = tagged_q.pop_front();
					if (result.field_tag !== want.field_tag)
						flag($sformatf("field_tag %0d, want %0d", result.field_tag, want.field_tag));
					if (result.data_byte !== want.data_byte)
						flag($sformatf("data_byte %02h, want %02h", result.data_byte, want.data_byte));
					if (result.record_ok !== want.record_ok)
						flag($sformatf("record_ok %0d, want %0d", result.record_ok, want.record_ok));
				end
			end
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !idle_now();
			end
		end
	end

	function automatic void push_byte(input logic [7:0] b);
		frp_pkg::in_item_t it;
		it.kind = frp_pkg::KIND_BYTE;
		it.byte_value = b;
		stream_q.push_back(it);
		fed++;
	endfunction

	function automatic void push_eoi();
		frp_pkg::in_item_t it;
		it.kind = frp_pkg::KIND_EOI;
		it.byte_value = 8'($urandom_range(0, 255));
		stream_q.push_back(it);
		fed++;
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		case ($urandom_range(0, 15))
		0: begin
			c = 8'($urandom_range(0, 255));
			if (c == frp_pkg::CH_NL) c = 8'hFF;
		end
		1: c = frp_pkg::CH_SPACE;
		2: c = frp_pkg::CH_TAB;
		3: c = frp_pkg::CH_CR;
		default: c = 8'h41 + 8'($urandom_range(0, 25));
		endcase
		return c;
	endfunction

	function automatic void add_text(input int len);
		for (int i = 0; i < len; i++) rec_buf.push_back(text_byte());
	endfunction

	function automatic void add_line(input int len);
		add_text(len);
		rec_buf.push_back(frp_pkg::CH_NL);
	endfunction

	function automatic void add_separator(input bit with_cr);
		case ($urandom_range(0, with_cr ? 2 : 1))
		0: rec_buf.push_back(frp_pkg::CH_SPACE);
		1: rec_buf.push_back(frp_pkg::CH_TAB);
		default: rec_buf.push_back(frp_pkg::CH_CR);
		endcase
	endfunction

	// Sends the built record, sometimes cut short, and closes it by an end of input when cut or when eoi_after is set.
	function automatic void flush_record(input bit eoi_after);
		int n;
		n = rec_buf.size();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(0, rec_buf.size());
			eoi_after = 1'b1;
		end
		for (int i = 0; i < n; i++) push_byte(rec_buf[i]);
		if (eoi_after) push_eoi();
	endfunction

	function automatic void fasta_record();
		rec_buf.delete();
		rec_buf.push_back(frp_pkg::CH_GT);
		add_text($urandom_range(1, 6));
		if ($urandom_range(0, 2) != 0) begin
			add_separator(1'b1);
			add_text($urandom_range(0, 6));
		end
		rec_buf.push_back(frp_pkg::CH_NL);
		repeat ($urandom_range(0, 3)) add_line($urandom_range(0, 10));
		flush_record($urandom_range(0, 7) == 0);
	endfunction

	function automatic void fastq_record();
		bit open_tail;
		rec_buf.delete();
		rec_buf.push_back(frp_pkg::CH_AT);
		add_text($urandom_range(1, 6));
		if ($urandom_range(0, 2) != 0) begin
			add_separator(1'b0);
			add_text($urandom_range(0, 6));
		end
		rec_buf.push_back(frp_pkg::CH_NL);
		add_line($urandom_range(0, 12));
		repeat ($urandom_range(0, 2)) add_line($urandom_range(0, 5));
		rec_buf.push_back(frp_pkg::CH_PLUS);
		add_text($urandom_range(0, 3));
		rec_buf.push_back(frp_pkg::CH_NL);
		add_text($urandom_range(0, 12));
		open_tail = $urandom_range(0, 5) == 0;
		if (!open_tail) rec_buf.push_back(frp_pkg::CH_NL);
		flush_record(open_tail);
	endfunction

	function automatic void noise_line();
		repeat ($urandom_range(0, 10)) begin
			if ($urandom_range(0, 3) == 0) push_byte(frp_pkg::CH_NL);
			else push_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1) != 0) push_byte(frp_pkg::CH_NL);
	endfunction

	function automatic void random_stream(input int n, input bit fastq);
		int target;
		int pick;
		target = fed + n;
		while (fed < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if (fastq) fastq_record();
				else fasta_record();
			end else if (pick < 85) begin
				noise_line();
			end else if (pick < 93) begin
				if (fastq) fasta_record();
				else fastq_record();
			end else begin
				push_eoi();
			end
		end
	endfunction

	// Waits until every queued item has gone in and every predicted result has come out.
	task automatic settle();
		do @(negedge clk); while (stream_q.size() != 0 || item_valid || tagged_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(frp_pkg::PDATA_W-1){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		frp_pkg::REG_FORMAT_FASTQ: begin
			cfg.format_fastq = v;
			st = frp_pkg::STATE_RESET;
		end
		frp_pkg::REG_DROP_NAME: cfg.drop_name = v;
		frp_pkg::REG_DROP_SEQUENCE: cfg.drop_sequence = v;
		default: cfg.drop_quality = v;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(frp_pkg::PDATA_W-1){1'b0}}, v})
			flag($sformatf("register %0d reads %08h, want %0d", idx, prdata, v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		#200_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// FASTA at reset settings: nameless record, tab and CR separators, empty line,
		// header without lines, end of input with nothing open, extreme bytes.
		push_str("A\n>n\tc\n\n>q\015z\n");
		push_eoi();
		push_eoi();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_eoi();
		random_stream(200, 1'b0);
		hold_asks <= hold_asks + 1;
		settle();

		// FASTQ: CR inside the name, skipped line before '+', partial quality at end of input.
		write_reg(frp_pkg::REG_FORMAT_FASTQ, 1'b1);
		push_str("@r\015 c\nG\nj\n+\nQ\n");
		push_str("@\n\n+\nZ");
		push_eoi();
		random_stream(120, 1'b1);
		settle();
		random_stream(130, 1'b1);
		settle();

		write_reg(frp_pkg::REG_DROP_NAME, 1'b1);
		write_reg(frp_pkg::REG_DROP_QUALITY, 1'b1);
		steady <= 1'b1;
		random_stream(150, 1'b1);
		settle();
		steady <= 1'b0;

		write_reg(frp_pkg::REG_FORMAT_FASTQ, 1'b0);
		write_reg(frp_pkg::REG_DROP_NAME, 1'b0);
		write_reg(frp_pkg::REG_DROP_SEQUENCE, 1'b1);
		random_stream(150, 1'b0);
		settle();

		write_reg(frp_pkg::REG_FORMAT_FASTQ, 1'b1);
		write_reg(frp_pkg::REG_DROP_NAME, 1'b1);
		write_reg(frp_pkg::REG_DROP_QUALITY, 1'b0);
		random_stream(150, 1'b1);
		settle();

		write_reg(frp_pkg::REG_FORMAT_FASTQ, 1'b0);
		write_reg(frp_pkg::REG_DROP_NAME, 1'b0);
		write_reg(frp_pkg::REG_DROP_SEQUENCE, 1'b0);
		random_stream(100, 1'b0);
		repeat (30) noise_line();
		settle();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && tagged_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
